// ===== hdl/postfix_expression_evaluator_unit_assert.svh =====
// Assertion macros used by the RTL of the postfix evaluator.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PEE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PEE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pee_pkg.sv =====
`default_nettype none
package pee_pkg;

    localparam int VALUE_WIDTH = 48;
    localparam int FRAC_BITS = 16;
    localparam int QUOT_WIDTH = 64;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;
    typedef logic [VALUE_WIDTH-1:0] t_mag;
    typedef logic [QUOT_WIDTH-1:0] t_quot;
    typedef logic [2:0] t_op;
    typedef logic [1:0] t_status;

    localparam t_op OP_ADD = 3'd0;
    localparam t_op OP_SUB = 3'd1;
    localparam t_op OP_MUL = 3'd2;
    localparam t_op OP_DIV = 3'd3;
    localparam t_op OP_POW = 3'd4;

    localparam t_status ST_OK = 2'd0;
    localparam t_status ST_COUNT = 2'd1;
    localparam t_status ST_OVERFLOW = 2'd2;
    localparam t_status ST_UNDERFLOW = 2'd3;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;

    localparam t_value VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam t_value VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam t_value VAL_ONE = t_value'(1) <<< FRAC_BITS;
    localparam t_quot MAG_POS = {{(QUOT_WIDTH-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
    localparam t_quot MAG_NEG = MAG_POS + QUOT_WIDTH'(1);

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_req;

    typedef struct packed {
        t_value  result_value;
        t_status status;
        logic    saturated;
        logic    divide_by_zero;
    } t_out_req;

    typedef struct packed {
        t_value value;
        logic   sat;
        logic   dz;
    } t_alu_res;

    function automatic t_mag f_mag(input t_value v);
        t_mag u;
        u = v;
        return v[VALUE_WIDTH-1] ? (~u + 1'b1) : u;
    endfunction

    function automatic t_alu_res f_from_mag(input logic neg, input t_quot mag);
        t_quot m;
        t_quot nm;
        t_alu_res r;
        m = mag;
        r.sat = 1'b0;
        r.dz = 1'b0;
        if (neg) begin
            if (mag > MAG_NEG) begin
                r.sat = 1'b1;
                m = MAG_NEG;
            end
            nm = QUOT_WIDTH'(0) - m;
            r.value = nm[VALUE_WIDTH-1:0];
        end else begin
            if (mag > MAG_POS) begin
                r.sat = 1'b1;
                m = MAG_POS;
            end
            r.value = m[VALUE_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/pee_ram.sv =====
`default_nettype none
module pee_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/pee_alu.sv =====
`default_nettype none
module pee_alu import pee_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_start,
    input  wire t_op    i_op,
    input  wire t_value i_left,
    input  wire t_value i_right,
    output logic        o_done,
    output t_alu_res    o_res
);

    localparam logic [1:0] A_IDLE = 2'd0;
    localparam logic [1:0] A_MUL = 2'd1;
    localparam logic [1:0] A_DIV = 2'd2;
    localparam logic [6:0] MUL_STEPS = 7'(VALUE_WIDTH);
    localparam logic [6:0] DIV_STEPS = 7'(QUOT_WIDTH);
    localparam int PW = VALUE_WIDTH - FRAC_BITS;

    logic [1:0]  r_state;
    logic [6:0]  r_step;
    logic        r_is_pow;
    logic        r_mneg;
    logic        r_bneg;
    t_mag        r_mb;
    t_mag        r_ph;
    t_mag        r_pl;
    t_mag        r_rem;
    t_quot       r_dq;
    t_value      r_cur;
    t_value      r_prev;
    logic        r_have_prev;
    logic [PW-1:0] r_left;
    logic        r_sat;
    logic        r_done;
    t_alu_res    r_res;

    logic [VALUE_WIDTH:0]     mul_sum;
    logic [2*VALUE_WIDTH-1:0] prod;
    logic [2*VALUE_WIDTH-1:0] prod_q;
    t_quot                    mul_q;
    t_alu_res                 mul_fm;
    logic [VALUE_WIDTH:0]     div_t;
    logic                     div_ge;
    logic [VALUE_WIDTH:0]     div_diff;
    t_alu_res                 div_fm;
    logic [VALUE_WIDTH:0]     s_add;
    logic [VALUE_WIDTH:0]     s_sub;
    logic                     add_ovf;
    logic                     sub_ovf;
    logic [PW-1:0]            left_n;
    logic                     sat_all;

    always_comb begin
        mul_sum = {1'b0, r_ph} + (r_pl[0] ? {1'b0, r_mb} : '0);
        prod = {r_ph, r_pl};
        prod_q = prod >> FRAC_BITS;
        mul_q = (|prod_q[2*VALUE_WIDTH-1:QUOT_WIDTH]) ? '1 : prod_q[QUOT_WIDTH-1:0];
        mul_fm = f_from_mag(r_mneg, mul_q);
        div_t = {r_rem, r_dq[QUOT_WIDTH-1]};
        div_ge = div_t >= {1'b0, r_mb};
        div_diff = div_t - {1'b0, r_mb};
        div_fm = f_from_mag(r_mneg, r_dq);
        s_add = {i_left[VALUE_WIDTH-1], i_left} + {i_right[VALUE_WIDTH-1], i_right};
        s_sub = {i_left[VALUE_WIDTH-1], i_left} - {i_right[VALUE_WIDTH-1], i_right};
        add_ovf = s_add[VALUE_WIDTH] != s_add[VALUE_WIDTH-1];
        sub_ovf = s_sub[VALUE_WIDTH] != s_sub[VALUE_WIDTH-1];
        left_n = r_left - PW'(1);
        sat_all = r_sat | mul_fm.sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                A_IDLE: begin
                    if (i_start) begin
                        r_ph <= '0;
                        r_step <= '0;
                        r_sat <= 1'b0;
                        r_mneg <= i_left[VALUE_WIDTH-1] ^ i_right[VALUE_WIDTH-1];
                        unique case (i_op)
                            OP_ADD: begin
                                r_res.value <= add_ovf ? (s_add[VALUE_WIDTH] ? VAL_MIN : VAL_MAX)
                                                       : s_add[VALUE_WIDTH-1:0];
                                r_res.sat <= add_ovf;
                                r_res.dz <= 1'b0;
                                r_done <= 1'b1;
                            end
                            OP_SUB: begin
                                r_res.value <= sub_ovf ? (s_sub[VALUE_WIDTH] ? VAL_MIN : VAL_MAX)
                                                       : s_sub[VALUE_WIDTH-1:0];
                                r_res.sat <= sub_ovf;
                                r_res.dz <= 1'b0;
                                r_done <= 1'b1;
                            end
                            OP_MUL: begin
                                r_pl <= f_mag(i_left);
                                r_mb <= f_mag(i_right);
                                r_is_pow <= 1'b0;
                                r_state <= A_MUL;
                            end
                            OP_DIV: begin
                                if (i_right == '0) begin
                                    r_res.value <= i_left[VALUE_WIDTH-1] ? VAL_MIN : VAL_MAX;
                                    r_res.sat <= 1'b1;
                                    r_res.dz <= 1'b1;
                                    r_done <= 1'b1;
                                end else begin
                                    r_mb <= f_mag(i_right);
                                    r_dq <= QUOT_WIDTH'(f_mag(i_left)) << FRAC_BITS;
                                    r_rem <= '0;
                                    r_state <= A_DIV;
                                end
                            end
                            OP_POW: begin
                                if (i_right[VALUE_WIDTH-1] || i_right[VALUE_WIDTH-1:FRAC_BITS] == '0) begin
                                    r_res.value <= VAL_ONE;
                                    r_res.sat <= 1'b0;
                                    r_res.dz <= 1'b0;
                                    r_done <= 1'b1;
                                end else begin
                                    r_cur <= VAL_ONE;
                                    r_have_prev <= 1'b0;
                                    r_left <= i_right[VALUE_WIDTH-1:FRAC_BITS];
                                    r_pl <= VAL_ONE;
                                    r_mb <= f_mag(i_left);
                                    r_bneg <= i_left[VALUE_WIDTH-1];
                                    r_mneg <= i_left[VALUE_WIDTH-1];
                                    r_is_pow <= 1'b1;
                                    r_state <= A_MUL;
                                end
                            end
                            default: begin
                                r_res <= '0;
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                A_MUL: begin
                    if (r_step != MUL_STEPS) begin
                        r_ph <= mul_sum[VALUE_WIDTH:1];
                        r_pl <= {mul_sum[0], r_pl[VALUE_WIDTH-1:1]};
                        r_step <= r_step + 7'd1;
                    end else if (!r_is_pow) begin
                        r_res <= mul_fm;
                        r_done <= 1'b1;
                        r_state <= A_IDLE;
                    end else begin
                        r_res.sat <= sat_all;
                        r_res.dz <= 1'b0;
                        priority if (mul_fm.value == r_cur) begin
                            r_res.value <= r_cur;
                            r_done <= 1'b1;
                            r_state <= A_IDLE;
                        end else if (r_have_prev && mul_fm.value == r_prev) begin
                            r_res.value <= left_n[0] ? r_cur : mul_fm.value;
                            r_done <= 1'b1;
                            r_state <= A_IDLE;
                        end else if (left_n == '0) begin
                            r_res.value <= mul_fm.value;
                            r_done <= 1'b1;
                            r_state <= A_IDLE;
                        end else begin
                            r_prev <= r_cur;
                            r_cur <= mul_fm.value;
                            r_have_prev <= 1'b1;
                            r_left <= left_n;
                            r_sat <= sat_all;
                            r_pl <= f_mag(mul_fm.value);
                            r_mneg <= mul_fm.value[VALUE_WIDTH-1] ^ r_bneg;
                            r_ph <= '0;
                            r_step <= '0;
                        end
                    end
                end
                A_DIV: begin
                    if (r_step != DIV_STEPS) begin
                        r_rem <= div_ge ? div_diff[VALUE_WIDTH-1:0] : div_t[VALUE_WIDTH-1:0];
                        r_dq <= {r_dq[QUOT_WIDTH-2:0], div_ge};
                        r_step <= r_step + 7'd1;
                    end else begin
                        r_res <= div_fm;
                        r_done <= 1'b1;
                        r_state <= A_IDLE;
                    end
                end
                default: begin
                    r_state <= A_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res = r_res;

endmodule
`default_nettype wire

// ===== hdl/postfix_expression_evaluator_unit.sv =====
`default_nettype none
// Postfix expression evaluator. Characters arrive on the input channel one request
// at a time (char_code, last_char); digits push, + - * / ^ pop two values and push
// the result, anything else is ignored. Values are signed Q31.16 and saturate.
// Only the character marked last produces an output request carrying the value,
// the status and the sticky saturation and divide-by-zero flags.
// The stack lives in a single-port-read RAM with the top entry held in a register.
// A digit or ignored character is taken straight from idle. An operator reads the
// left operand from the RAM, then the ALU adds or subtracts, multiplies by
// shift-add over the value width, divides by restoring division (one quotient
// bit per cycle) and raises to a power by repeated multiplication.
// Emission of the last character loads the output register, which holds the
// request while the receiver stalls; further characters are still taken then, but
// another last character waits until the output register is free.
// A synchronous reset empties the stack and clears all flags and the output valid.
module postfix_expression_evaluator_unit import pee_pkg::*; #(
    parameter int STACK_DEPTH = 256
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_req  i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_req      o_out_data
);

    `include "postfix_expression_evaluator_unit_assert.svh"

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]    r_state;
    logic [CW-1:0] r_count;
    t_status       r_err;
    logic          r_sat;
    logic          r_dz;
    t_value        r_tos;
    t_op           r_op;
    logic          r_last;
    logic          r_out_valid;
    t_out_req      r_out;

    logic [7:0]    ch;
    logic          is_digit;
    logic          is_op;
    t_op           op_code;
    logic          in_acc;
    logic          acc_digit;
    logic          acc_op;
    logic          full;
    logic          op_ok;
    logic [CW-1:0] count_m1;
    logic [CW-1:0] count_m2;
    logic          ram_we;
    t_value        ram_rdata;
    logic          alu_done;
    t_alu_res      alu_res;
    t_status       emit_status;

    always_comb begin
        ch = i_in_data.char_code;
        is_digit = ch >= CH_ZERO && ch <= CH_NINE;
        is_op = ch == CH_PLUS || ch == CH_MINUS || ch == CH_STAR || ch == CH_SLASH ||
                ch == CH_CARET;
        op_code = (ch == CH_PLUS) ? OP_ADD :
                  (ch == CH_MINUS) ? OP_SUB :
                  (ch == CH_STAR) ? OP_MUL :
                  (ch == CH_SLASH) ? OP_DIV : OP_POW;
        o_in_ready = r_state == S_IDLE &&
                     (!i_in_data.last_char || !r_out_valid || i_out_ready);
        in_acc = i_in_valid && o_in_ready;
        acc_digit = in_acc && r_err == ST_OK && is_digit;
        acc_op = in_acc && r_err == ST_OK && is_op;
        full = r_count == CW'(STACK_DEPTH);
        op_ok = r_count >= CW'(2);
        count_m1 = r_count - CW'(1);
        count_m2 = r_count - CW'(2);
        ram_we = acc_digit && !full && r_count != '0;
        emit_status = (r_err != ST_OK) ? r_err :
                      (r_count != CW'(1)) ? ST_COUNT : ST_OK;
    end

    pee_ram #(
        .WIDTH(VALUE_WIDTH),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (count_m1[AW-1:0]),
        .i_wdata (r_tos),
        .i_re    (in_acc),
        .i_raddr (count_m2[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    pee_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_READ),
        .i_op    (r_op),
        .i_left  (ram_rdata),
        .i_right (r_tos),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_err <= ST_OK;
            r_sat <= 1'b0;
            r_dz <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_last <= i_in_data.last_char;
                        if (i_in_data.last_char && !(acc_op && op_ok)) begin
                            r_state <= S_EMIT;
                        end
                    end
                    if (acc_digit) begin
                        if (full) begin
                            r_err <= ST_OVERFLOW;
                        end else begin
                            r_tos <= t_value'(ch[3:0]) <<< FRAC_BITS;
                            r_count <= r_count + CW'(1);
                        end
                    end
                    if (acc_op) begin
                        if (!op_ok) begin
                            r_err <= ST_UNDERFLOW;
                        end else begin
                            r_op <= op_code;
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (alu_done) begin
                        r_tos <= alu_res.value;
                        r_count <= count_m1;
                        r_sat <= r_sat | alu_res.sat;
                        r_dz <= r_dz | alu_res.dz;
                        r_state <= r_last ? S_EMIT : S_IDLE;
                    end
                end
                S_EMIT: begin
                    r_out.result_value <= (emit_status == ST_OK) ? r_tos : '0;
                    r_out.status <= emit_status;
                    r_out.saturated <= r_sat;
                    r_out.divide_by_zero <= r_dz;
                    r_out_valid <= 1'b1;
                    r_count <= '0;
                    r_err <= ST_OK;
                    r_sat <= 1'b0;
                    r_dz <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

    `PEE_ASSERT_NOW(a_alu_done_in_exec, i_clk, i_rst_n, alu_done, r_state == S_EXEC,
        "ALU finished outside of the execute state")
    `PEE_ASSERT_NEXT(a_emit_clears, i_clk, i_rst_n, r_state == S_EMIT,
        r_count == '0 && r_err == ST_OK && o_out_valid,
        "Emission did not clear the expression state")
    `PEE_ASSERT_NEXT(a_op_fetches, i_clk, i_rst_n, acc_op && op_ok, r_state == S_READ,
        "Accepted operator did not fetch its left operand")

endmodule
`default_nettype wire

// ===== dv/postfix_expression_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
module postfix_expression_checker import pee_pkg::*; #(
    parameter int STACK_DEPTH = 256
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_in_ready,
    input  wire t_in_req  i_in_data,
    input  wire logic     i_out_valid,
    input  wire logic     i_out_ready,
    input  wire t_out_req i_out_data,
    output int            o_fail_count,
    output int            o_pending
);

    localparam longint VMAX = longint'(VAL_MAX);
    localparam longint VMIN = longint'(VAL_MIN);

    longint   value_stack [STACK_DEPTH];
    int       depth;
    t_status  err_code;
    logic     sat_seen;
    logic     dz_seen;
    t_out_req expected_results [$];

    function automatic logic [127:0] mag_of(input longint v);
        return v < 0 ? 128'(-v) : 128'(v);
    endfunction

    function automatic longint fit_mag(input logic neg, input logic [127:0] mag);
        logic [127:0] m;
        m = mag;
        if (neg) begin
            if (m > 128'(VMAX) + 1) begin
                sat_seen = 1'b1;
                m = 128'(VMAX) + 1;
            end
            return -longint'(m[63:0]);
        end
        if (m > 128'(VMAX)) begin
            sat_seen = 1'b1;
            m = 128'(VMAX);
        end
        return longint'(m[63:0]);
    endfunction

    function automatic longint clamp_sum(input longint v);
        if (v > VMAX) begin
            sat_seen = 1'b1;
            return VMAX;
        end
        if (v < VMIN) begin
            sat_seen = 1'b1;
            return VMIN;
        end
        return v;
    endfunction

    function automatic longint fixed_mul(input longint a, input longint b);
        logic [127:0] p;
        p = mag_of(a) * mag_of(b);
        return fit_mag((a < 0) != (b < 0), p >> FRAC_BITS);
    endfunction

    function automatic longint fixed_div(input longint a, input longint b);
        logic [127:0] q;
        if (b == 0) begin
            dz_seen = 1'b1;
            sat_seen = 1'b1;
            return a < 0 ? VMIN : VMAX;
        end
        q = (mag_of(a) << FRAC_BITS) / mag_of(b);
        return fit_mag((a < 0) != (b < 0), q);
    endfunction

    // Repeated multiplication stops early once the running value settles
    // or starts alternating between two values.
    function automatic longint fixed_pow(input longint base, input longint ex);
        longint cur;
        longint prev;
        longint nxt;
        logic   have_prev;
        longint remaining;
        cur = fit_mag(1'b0, 128'(1) << FRAC_BITS);
        prev = 0;
        have_prev = 1'b0;
        if (ex < 0) return cur;
        remaining = ex >>> FRAC_BITS;
        while (remaining > 0) begin
            nxt = fixed_mul(cur, base);
            remaining--;
            if (nxt == cur) break;
            if (have_prev && nxt == prev) begin
                cur = remaining[0] ? cur : nxt;
                break;
            end
            prev = cur;
            cur = nxt;
            have_prev = 1'b1;
        end
        return cur;
    endfunction

    function automatic void eval_char(input t_in_req req);
        longint   lhs;
        longint   rhs;
        longint   res;
        t_out_req outcome;
        logic     is_op;
        is_op = req.char_code inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};
        if (err_code == ST_OK) begin
            if (req.char_code >= CH_ZERO && req.char_code <= CH_NINE) begin
                if (depth >= STACK_DEPTH) begin
                    err_code = ST_OVERFLOW;
                end else begin
                    value_stack[depth] = longint'(req.char_code - CH_ZERO) <<< FRAC_BITS;
                    depth++;
                end
            end else if (is_op) begin
                if (depth < 2) begin
                    err_code = ST_UNDERFLOW;
                end else begin
                    rhs = value_stack[depth-1];
                    lhs = value_stack[depth-2];
                    case (req.char_code)
                        CH_PLUS:  res = clamp_sum(lhs + rhs);
                        CH_MINUS: res = clamp_sum(lhs - rhs);
                        CH_STAR:  res = fixed_mul(lhs, rhs);
                        CH_SLASH: res = fixed_div(lhs, rhs);
                        default:  res = fixed_pow(lhs, rhs);
                    endcase
                    depth--;
                    value_stack[depth-1] = res;
                end
            end
        end
        if (req.last_char) begin
            outcome.status = err_code;
            outcome.result_value = '0;
            if (err_code == ST_OK) begin
                if (depth != 1) outcome.status = ST_COUNT;
                else outcome.result_value = t_value'(value_stack[0]);
            end
            outcome.saturated = sat_seen;
            outcome.divide_by_zero = dz_seen;
            expected_results.push_back(outcome);
            depth = 0;
            err_code = ST_OK;
            sat_seen = 1'b0;
            dz_seen = 1'b0;
        end
    endfunction

    initial begin
        depth = 0;
        err_code = ST_OK;
        sat_seen = 1'b0;
        dz_seen = 1'b0;
        o_fail_count = 0;
    end

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_out_req want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result request %h", i_out_data);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.result_value !== want.result_value) begin
                        $error("result_value expected %0d got %0d",
                               want.result_value, i_out_data.result_value);
                        o_fail_count++;
                    end
                    if (i_out_data.status !== want.status) begin
                        $error("status expected %0d got %0d", want.status, i_out_data.status);
                        o_fail_count++;
                    end
                    if (i_out_data.saturated !== want.saturated) begin
                        $error("saturated expected %0b got %0b",
                               want.saturated, i_out_data.saturated);
                        o_fail_count++;
                    end
                    if (i_out_data.divide_by_zero !== want.divide_by_zero) begin
                        $error("divide_by_zero expected %0b got %0b",
                               want.divide_by_zero, i_out_data.divide_by_zero);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) eval_char(i_in_data);
        end
    end

endmodule
`default_nettype wire

// ===== dv/tb_postfix_expression_evaluator_unit.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_postfix_expression_evaluator_unit;
    import pee_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int PHASE_ITEMS = 320;
    localparam int STACK_DEPTH_TB = 256;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_ready;
    t_in_req  i_in_data;
    logic     o_out_valid;
    logic     i_out_ready;
    t_out_req o_out_data;
    int       fail_count;
    int       pending;
    int       send_idle_pct;
    int       stall_pct;
    int       phase;
    int       hold_left;
    logic     hold_done;
    int       cycle_count;
    int       sent_count;

    postfix_expression_evaluator_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    postfix_expression_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_in_data(i_in_data),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_out_data(o_out_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        phase = 0;
        hold_left = 0;
        hold_done = 1'b0;
        cycle_count = 0;
    end

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // The long hold-off lets the output register and then the input side back up.
    always @(posedge i_clk) begin
        if (phase == 1 && !hold_done) begin
            hold_left <= 3000;
            hold_done <= 1'b1;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= $urandom_range(99) >= stall_pct;
        end
    end

    task automatic send_char(input logic [7:0] ch, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= '{char_code: ch, last_char: last};
        do @(posedge i_clk); while (!o_in_ready);
        sent_count++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_char(s[k], k == s.len() - 1);
    endtask

    // Builds a well-formed expression; a power only ever takes a plain digit
    // as its exponent so that runs stay short.
    task automatic send_expression();
        logic [7:0] chars [$];
        logic       digit_top [$];
        int         pushes;
        int         want;
        logic [7:0] op;
        want = ($urandom_range(9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 6);
        pushes = 0;
        while (pushes < want || digit_top.size() > 1) begin
            if (digit_top.size() < 2 || (pushes < want && $urandom_range(1) == 0)) begin
                chars.push_back(CH_ZERO + 8'($urandom_range(9)));
                digit_top.push_back(1'b1);
                pushes++;
            end else begin
                case ($urandom_range(4))
                    0: op = CH_PLUS;
                    1: op = CH_MINUS;
                    2: op = CH_STAR;
                    3: op = CH_SLASH;
                    default: op = digit_top[$] ? CH_CARET : CH_STAR;
                endcase
                chars.push_back(op);
                void'(digit_top.pop_back());
                digit_top[$] = 1'b0;
            end
            if ($urandom_range(15) == 0) chars.push_back(8'h20);
        end
        foreach (chars[k]) send_char(chars[k], k == chars.size() - 1);
    endtask

    task automatic send_noise();
        int         n;
        logic [7:0] ch;
        n = $urandom_range(1, 10);
        for (int k = 0; k < n; k++) begin
            ch = 8'($urandom_range(255));
            if (ch == CH_CARET) ch = CH_STAR;
            send_char(ch, k == n - 1);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_text("12+");
        send_text("93-");
        send_text("34*");
        send_text("84/");
        send_text("13/");
        send_text("50/");
        send_text("05-0/");
        send_text("23^");
        send_text("205-^");
        send_text("00^");
        send_text("99*9*9*9*9*9*9*9*9*9*");
        send_text("099*9*9*9*9*9*9*9*9*9*-");
        send_text("x");
        send_text("12");
        send_text("+1+2");
        for (int k = 0; k < STACK_DEPTH_TB; k++) send_char(CH_NINE, 1'b0);
        send_char(CH_ZERO, 1'b0);
        send_char(CH_PLUS, 1'b1);
        send_char(8'hFF, 1'b1);

        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct = (phase == 1) ? 81 : (phase == 3) ? 34 : 0;
            stall_pct = (phase == 2) ? 81 : (phase == 3) ? 34 : 0;
            sent_count = 0;
            while (sent_count < PHASE_ITEMS) begin
                if ($urandom_range(99) < 85) send_expression();
                else send_noise();
            end
        end
        i_in_valid <= 1'b0;
        @(posedge i_clk);

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire
